>>> src/sprite_xor_framebuffer_macros.svh
// Assertion macros shared by the framebuffer RTL.
`ifndef SPRITE_XOR_FRAMEBUFFER_MACROS_SVH
`define SPRITE_XOR_FRAMEBUFFER_MACROS_SVH

// Check cons in the same cycle as ante.
`define SXF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SXF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sxf_pkg.sv
// Types, constants and wrap tables for the sprite framebuffer.
`default_nettype none

package sxf_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;

    // Sprite row geometry: eight pixels, bit 7 leftmost
    localparam int SPRITE_PIXELS = 8;
    localparam int SPRITE_MSB    = 7;

    localparam int COL_W = $clog2(SCREEN_WIDTH);
    localparam int ROW_W = $clog2(SCREEN_HEIGHT);

    localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(SCREEN_WIDTH);
    localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(SCREEN_HEIGHT);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [3:0] row_index;
        logic [7:0] sprite_row;
    } cmd_t;

    typedef struct packed {
        logic       collision;
        logic [7:0] pixels_out;
    } res_t;

    // Write request from the row datapath to the frame store
    typedef struct packed {
        logic                    wr_en;
        logic                    clear;
        logic [ROW_W-1:0]        row;
        logic [SCREEN_WIDTH-1:0] data;
        logic                    flag_en;
        logic                    flag;
    } frame_wr_t;

    typedef logic [COL_W-1:0] col_tab_t [256];
    typedef logic [ROW_W-1:0] row_tab_t [256];
    typedef logic [ROW_W-1:0] idx_tab_t [16];

    function automatic col_tab_t build_col_tab();
        col_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = COL_W'(i % SCREEN_WIDTH);
        end
        return t;
    endfunction

    function automatic row_tab_t build_row_tab();
        row_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = ROW_W'(i % SCREEN_HEIGHT);
        end
        return t;
    endfunction

    function automatic idx_tab_t build_idx_tab();
        idx_tab_t t;
        for (int i = 0; i < 16; i++) begin
            t[i] = ROW_W'(i % SCREEN_HEIGHT);
        end
        return t;
    endfunction

    // Byte-wide coordinates and the 4-bit row index reduced modulo the screen size
    localparam col_tab_t COL_WRAP = build_col_tab();
    localparam row_tab_t ROW_WRAP = build_row_tab();
    localparam idx_tab_t IDX_WRAP = build_idx_tab();

endpackage

`default_nettype wire

>>> src/sxf_frame.sv
// Frame store: one register row per screen line plus the collision flag.
`default_nettype none

module sxf_frame
    import sxf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [ROW_W-1:0]        rd_row,
    output logic      [SCREEN_WIDTH-1:0] rd_data,
    output logic                         flag,
    input  wire frame_wr_t               wr
);

    logic [SCREEN_WIDTH-1:0] frame_reg  [SCREEN_HEIGHT];
    logic [SCREEN_WIDTH-1:0] frame_next [SCREEN_HEIGHT];
    logic                    flag_reg;
    logic                    flag_next;

    // Read one line
    assign rd_data = frame_reg[rd_row];
    assign flag    = flag_reg;

    // Clear every line or replace the addressed one
    always_comb
    begin
        frame_next = frame_reg;
        if (wr.wr_en)
        begin
            if (wr.clear)
            begin
                for (int r = 0; r < SCREEN_HEIGHT; r++)
                begin
                    frame_next[r] = '0;
                end
            end
            else
            begin
                frame_next[wr.row] = wr.data;
            end
        end
    end

    // Update the sticky flag
    always_comb
    begin
        flag_next = flag_reg;
        if (wr.flag_en)
        begin
            flag_next = wr.flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SCREEN_HEIGHT; r++)
            begin
                frame_reg[r] <= '0;
            end
            flag_reg <= 1'b0;
        end
        else
        begin
            frame_reg <= frame_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sxf_row_op.sv
// Row datapath: wraps coordinates, XORs a sprite row, gathers read pixels.
`default_nettype none

module sxf_row_op
    import sxf_pkg::*;
(
    input  wire logic                    fire,
    input  wire cmd_t                    cmd,
    input  wire logic [SCREEN_WIDTH-1:0] rd_data,
    input  wire logic                    flag,
    output logic      [ROW_W-1:0]        rd_row,
    output frame_wr_t                    wr,
    output res_t                         res
);

    logic [ROW_W-1:0]        row_base;
    logic [ROW_W:0]          row_sum;
    logic [ROW_W-1:0]        draw_row;
    logic [COL_W-1:0]        col_base;
    logic [COL_W:0]          col_sum;
    logic [COL_W-1:0]        col_k;
    logic [SCREEN_WIDTH-1:0] mask;
    logic [7:0]              pix;
    logic                    hit;
    logic                    flag_start;
    logic                    flag_new;
    logic                    is_draw;
    logic                    is_clear;
    logic                    is_read;

    assign is_draw  = (cmd.opcode == OP_DRAW);
    assign is_clear = (cmd.opcode == OP_CLEAR);
    assign is_read  = (cmd.opcode == OP_READ);

    // Wrap the target line: both terms are already below the height
    always_comb
    begin
        row_base = ROW_WRAP[cmd.pos_y];
        row_sum  = {1'b0, row_base} + {1'b0, IDX_WRAP[cmd.row_index]};
        if (row_sum >= ROW_LIMIT)
        begin
            row_sum = row_sum - ROW_LIMIT;
        end
        draw_row = row_sum[ROW_W-1:0];
        rd_row   = is_draw ? draw_row : row_base;
    end

    // Place each sprite bit at its wrapped column and pick up read pixels
    always_comb
    begin
        col_base = COL_WRAP[cmd.pos_x];
        mask     = '0;
        pix      = '0;
        col_sum  = '0;
        col_k    = '0;
        for (int k = 0; k < SPRITE_PIXELS; k++)
        begin
            col_sum = {1'b0, col_base} + (COL_W + 1)'(k);
            if (col_sum >= COL_LIMIT)
            begin
                col_sum = col_sum - COL_LIMIT;
            end
            col_k = col_sum[COL_W-1:0];
            mask  = mask | (SCREEN_WIDTH'(cmd.sprite_row[SPRITE_MSB - k]) << col_k);
            pix[SPRITE_MSB - k] = rd_data[col_k];
        end
    end

    // Collision restarts at the first sprite row
    always_comb
    begin
        hit        = |(rd_data & mask);
        flag_start = (cmd.row_index == '0) ? 1'b0 : flag;
        flag_new   = flag_start | hit;
    end

    // Drive the store write and the result
    always_comb
    begin
        wr.wr_en   = fire && (is_draw || is_clear);
        wr.clear   = is_clear;
        wr.row     = draw_row;
        wr.data    = rd_data ^ mask;
        wr.flag_en = fire && is_draw;
        wr.flag    = flag_new;

        res.collision  = is_draw ? flag_new : flag;
        res.pixels_out = is_read ? pix : '0;
    end

endmodule

`default_nettype wire

>>> src/sprite_xor_framebuffer.sv
// Top level of the sprite XOR framebuffer: command and result registers.
//
//  Channel  Handshake             Payload  Notes
//  cmd      cmd_valid/cmd_stall   cmd_t    clear, draw row or read eight pixels
//  res      res_valid/res_stall   res_t    one result per command
//
// One command per cycle while res_stall is low; each passes the command then the result register.
// The whole frame sits in flip-flops, so a clear empties every line at once.
// Reset clears the frame, the collision flag and both valid bits at once.
// A stalled result holds the command register; cmd_stall rises only when
// both registers are full and res_stall is high.
`default_nettype none

`include "sprite_xor_framebuffer_macros.svh"

module sprite_xor_framebuffer
    import sxf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    logic                    cmd_valid_reg;
    logic                    cmd_valid_next;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    res_t                    res_reg;
    res_t                    res_next;
    logic                    advance;
    logic                    fire;
    logic [ROW_W-1:0]        rd_row;
    logic [SCREEN_WIDTH-1:0] rd_data;
    logic                    flag;
    frame_wr_t               wr;
    res_t                    op_res;

    // Move a transaction on when the result register is free or draining
    assign advance   = !res_valid_reg || !res_stall;
    assign fire      = cmd_valid_reg && advance;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    sxf_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_row  (rd_row),
        .rd_data (rd_data),
        .flag    (flag),
        .wr      (wr)
    );

    sxf_row_op u_row_op (
        .fire    (fire),
        .cmd     (cmd_reg),
        .rd_data (rd_data),
        .flag    (flag),
        .rd_row  (rd_row),
        .wr      (wr),
        .res     (op_res)
    );

    // Load the command register whenever it is not stalled
    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (!cmd_stall)
        begin
            cmd_valid_next = cmd_valid;
            if (cmd_valid)
            begin
                cmd_next = cmd;
            end
        end
    end

    // Capture the result as the command retires
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (advance)
        begin
            res_valid_next = cmd_valid_reg;
            if (fire)
            begin
                res_next = op_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    `SXF_ASSERT_NEXT(a_clear_empties, fire && cmd_reg.opcode == OP_CLEAR,
        rd_data == '0, "line not empty after clear")
    `SXF_ASSERT_NOW(a_res_from_cmd, $rose(res_valid_reg),
        $past(cmd_valid_reg), "result without command")
    `SXF_ASSERT_NEXT(a_flag_kept, fire && cmd_reg.opcode != OP_DRAW,
        res_reg.collision == $past(flag), "collision changed without draw")
    `SXF_ASSERT_NEXT(a_pixels_read_only, fire && cmd_reg.opcode != OP_READ,
        res_reg.pixels_out == '0, "pixels on non-read result")

endmodule

`default_nettype wire
